// ===== sv/lirm_pkg.sv =====
// ----------------------------------------------------------------------------
// lirm_pkg
// shared constants, register codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lirm_pkg;

  // parameter defaults
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int FRAME_BITS_DEF   = 20;
  localparam int SAMPLE_BITS_DEF  = 16;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CH_CFG_W  = 4;
  localparam int STEP_W    = 24;

  // result fields and limits
  localparam int CH_IDX_W    = 3;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = 7;
  localparam int FRAC_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CHANNELS  = 3'd0,
    REG_OUT_CHANNELS = 3'd1,
    REG_IN_FRAMES    = 3'd2,
    REG_OUT_FRAMES   = 3'd3,
    REG_STEP_Q16     = 3'd4
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input transaction taken
    logic div_start;  // start the mono average division
    logic mul;        // register the interpolation product
    logic rnd;        // form the frame value and advance position
    logic emit_next;  // output transaction taken, next channel
    logic commit;     // close the step
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finished;   // buffer input complete
    logic frame_full; // this sample completes an input frame
    logic div_done;   // mono average is ready
    logic frame_ok;   // another output frame may go out in this step
    logic last_chan;  // current output channel is the last one
  } sts_t;

endpackage

// ===== sv/lirm_div.sv =====
// ----------------------------------------------------------------------------
// lirm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lirm_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int RW  = DEN_W + 1;
  localparam int CW  = $clog2(NUM_W + 1);
  localparam logic [CW-1:0] LAST = CW'(NUM_W - 1);

  logic [RW-1:0]    rem_q, rem_d, rem_sh;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q[RW-2:0], quo_q[NUM_W-1]};
    ge     = rem_sh >= RW'(den_q);
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - RW'(den_q)) : rem_sh;
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/lirm_datapath.sv =====
// ----------------------------------------------------------------------------
// lirm_datapath
// configuration registers, channel mix-down, position tracking, interpolation
// ----------------------------------------------------------------------------
module lirm_datapath #(
  parameter int MAX_CHANNELS = 8,
  parameter int FRAME_BITS   = 20,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lirm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lirm_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  lirm_pkg::cmd_t                    cmd_i,
  output lirm_pkg::sts_t                    sts_o,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_o,
  output logic [lirm_pkg::CH_IDX_W-1:0]     channel_index_o,
  output logic [FRAME_BITS-1:0]             frame_index_o,
  output logic                              end_of_buffer_o
);

  import lirm_pkg::*;

  localparam int CNT_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int CUR_W  = SUM_W + 1;
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = CH_CFG_W + 1;
  localparam int DIFF_W = CUR_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;
  localparam int RQ_W   = PROD_W - FRAC_W;
  localparam int QS_W   = RQ_W + 1;
  localparam int V_W    = QS_W + 1;
  localparam int POS_W  = FRAME_BITS + FRAC_W;
  localparam int SMAX   = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [V_W-1:0] V_MAX = V_W'(SMAX);
  localparam logic signed [V_W-1:0] V_MIN = V_W'(-SMAX - 1);

  // configuration
  logic [CH_CFG_W-1:0]   in_ch_q, out_ch_q;
  logic [FRAME_BITS-1:0] in_frames_q, out_frames_q;
  logic [STEP_W-1:0]     step_q;

  // buffer state
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [CUR_W-1:0] prev_q, cur_q;
  logic [FRAME_BITS-1:0]   ifc_q, ofc_q;
  logic [POS_W-1:0]        pos_q;
  logic                    fin_q;

  // step state
  logic                    flush_q;
  logic [RES_W-1:0]        n_q;
  logic [CH_IDX_W-1:0]     ch_q;
  logic                    neg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SAMPLE_BITS-1:0]  val_q;
  logic [FRAME_BITS-1:0]   fidx_q;
  logic                    lastf_q;

  logic [CH_CFG_W-1:0]     nin, och, cnt_inc, ch_inc;
  logic                    final_frame, window_ok, ahead;
  logic [FRAME_BITS-1:0]   ip;
  logic [FRAC_W-1:0]       alpha;
  logic [SUM_W-1:0]        sum_mag;
  logic [NUM_W-1:0]        div_num;
  logic [NUM_W-1:0]        div_quo;
  logic                    div_done;
  logic signed [DIFF_W-1:0] diff;
  logic signed [FRAC_W:0]   alpha_s;
  logic [PROD_W-1:0]       prod_mag, prod_rnd;
  logic [RQ_W-1:0]         rq;
  logic signed [QS_W-1:0]  q_s;
  logic signed [V_W-1:0]   v_sum;
  logic [SAMPLE_BITS-1:0]  v_sat, v_sel;
  logic [POS_W:0]          pos_add;
  logic [FRAME_BITS:0]     ofc_inc;

  // channel counts, clamped into 1..MAX_CHANNELS
  always_comb begin
    if (in_ch_q == '0) nin = CH_CFG_W'(1);
    else if (in_ch_q > CH_CFG_W'(MAX_CHANNELS)) nin = CH_CFG_W'(MAX_CHANNELS);
    else nin = in_ch_q;
    if (out_ch_q == '0) och = CH_CFG_W'(1);
    else if (out_ch_q > CH_CFG_W'(MAX_CHANNELS)) och = CH_CFG_W'(MAX_CHANNELS);
    else och = out_ch_q;
  end

  assign cnt_inc     = CH_CFG_W'(cnt_q) + CH_CFG_W'(1);
  assign ch_inc      = CH_CFG_W'(ch_q) + CH_CFG_W'(1);
  assign final_frame = ({1'b0, ifc_q} + (FRAME_BITS+1)'(1)) >= {1'b0, in_frames_q};
  assign ip          = pos_q[POS_W-1:FRAC_W];
  assign alpha       = pos_q[FRAC_W-1:0];
  assign ahead       = ip >= ifc_q;
  assign window_ok   = flush_q || final_frame || !ahead;

  assign sts_o.finished   = fin_q;
  assign sts_o.frame_full = cnt_inc >= nin;
  assign sts_o.div_done   = div_done;
  assign sts_o.frame_ok   = (ofc_q < out_frames_q)
                         && ((n_q + RES_W'(och)) <= RES_W'(MAX_RESULTS))
                         && window_ok;
  assign sts_o.last_chan  = ch_inc == och;

  // mono average: (2|sum| + n) / (2n), sign restored afterwards
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_num = {sum_mag, 1'b0} + NUM_W'(nin);

  lirm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   ({nin, 1'b0}),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // interpolation: prev + round((cur - prev) * alpha / 2^16), saturated
  assign diff     = DIFF_W'(cur_q) - DIFF_W'(prev_q);
  assign alpha_s  = $signed({1'b0, alpha});
  assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign prod_rnd = prod_mag + PROD_W'(1 << (FRAC_W - 1));
  assign rq       = prod_rnd[PROD_W-1:FRAC_W];
  assign q_s      = prod_q[PROD_W-1] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
  assign v_sum    = V_W'(prev_q) + V_W'(q_s);

  always_comb begin
    if (v_sum > V_MAX) v_sat = V_MAX[SAMPLE_BITS-1:0];
    else if (v_sum < V_MIN) v_sat = V_MIN[SAMPLE_BITS-1:0];
    else v_sat = v_sum[SAMPLE_BITS-1:0];
    priority if (flush_q) v_sel = prev_q[SAMPLE_BITS-1:0];
    else if (ahead) v_sel = cur_q[SAMPLE_BITS-1:0];
    else v_sel = v_sat;
  end

  assign pos_add = {1'b0, pos_q} + (POS_W+1)'(step_q);
  assign ofc_inc = {1'b0, ofc_q} + (FRAME_BITS+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q      <= CH_CFG_W'(1);
      out_ch_q     <= CH_CFG_W'(2);
      in_frames_q  <= FRAME_BITS'(2);
      out_frames_q <= FRAME_BITS'(1);
      step_q       <= STEP_W'(65536);
      sum_q        <= '0;
      cnt_q        <= '0;
      prev_q       <= '0;
      ifc_q        <= '0;
      ofc_q        <= '0;
      pos_q        <= '0;
      fin_q        <= 1'b0;
      flush_q      <= 1'b0;
      n_q          <= '0;
      ch_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IN_CHANNELS:  in_ch_q      <= cfg_data_i[CH_CFG_W-1:0];
          REG_OUT_CHANNELS: out_ch_q     <= cfg_data_i[CH_CFG_W-1:0];
          REG_IN_FRAMES:    in_frames_q  <= cfg_data_i[FRAME_BITS-1:0];
          REG_OUT_FRAMES:   out_frames_q <= cfg_data_i[FRAME_BITS-1:0];
          REG_STEP_Q16:     step_q       <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        flush_q <= fin_q;
        n_q     <= '0;
        if (!fin_q) begin
          sum_q <= sum_q + SUM_W'(sample_i);
          if (!sts_o.frame_full) begin
            cnt_q <= cnt_inc[CNT_W-1:0];
          end
        end
      end
      if (cmd_i.rnd) begin
        ofc_q <= ofc_inc[FRAME_BITS-1:0];
        pos_q <= pos_add[POS_W] ? '1 : pos_add[POS_W-1:0];
        n_q   <= n_q + RES_W'(och);
        ch_q  <= '0;
      end
      if (cmd_i.emit_next) begin
        ch_q <= ch_q + CH_IDX_W'(1);
      end
      if (cmd_i.commit && !flush_q) begin
        prev_q <= cur_q;
        sum_q  <= '0;
        cnt_q  <= '0;
        if (final_frame) fin_q <= 1'b1;
        else ifc_q <= ifc_q + FRAME_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SUM_W-1];
    end
    if (div_done) begin
      cur_q <= neg_q ? -$signed({1'b0, div_quo[SUM_W-1:0]})
                     : $signed({1'b0, div_quo[SUM_W-1:0]});
    end
    if (cmd_i.mul) begin
      prod_q <= diff * alpha_s;
    end
    if (cmd_i.rnd) begin
      val_q   <= v_sel;
      fidx_q  <= ofc_q;
      lastf_q <= ofc_inc == {1'b0, out_frames_q};
    end
  end

  assign out_sample_o    = $signed(val_q);
  assign channel_index_o = ch_q;
  assign frame_index_o   = fidx_q;
  assign end_of_buffer_o = lastf_q && sts_o.last_chan;

endmodule

// ===== sv/lirm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lirm_ctrl
// step sequencer: accept, average, per-frame interpolate and emit channels
// ----------------------------------------------------------------------------
module lirm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           last_of_run_o,
  output lirm_pkg::cmd_t cmd_o,
  input  lirm_pkg::sts_t sts_i
);

  import lirm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_RND   = 9'b000100000,
    S_NEXT  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   more_q, more_d;

  always_comb begin
    state_d = state_q;
    more_d  = more_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (sts_i.finished) state_d = S_CHECK;
          else if (sts_i.frame_full) state_d = S_LOAD;
          else state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = sts_i.frame_ok ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_NEXT;
      end
      S_NEXT: begin
        more_d  = sts_i.frame_ok;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          if (sts_i.last_chan) begin
            state_d = more_q ? S_MUL : S_DONE;
          end else begin
            cmd_o.emit_next = 1'b1;
          end
        end
      end
      S_DONE: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = state_q == S_EMIT;
  assign last_of_run_o = sts_i.last_chan && !more_q;

endmodule

// ===== sv/linear_interp_resampler_mixdown.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_mixdown
// linear interpolation resampler with mono mix-down and multichannel copy-out
// ----------------------------------------------------------------------------
// Interleaved signed samples come in one per transaction; every in_channels of
// them are averaged into a mono frame (rounded to nearest, ties away from
// zero). A Q.16 source position advances by step_q16 per output frame, and
// each output frame is prev + alpha * (cur - prev), rounded and saturated,
// sent out once per output channel. The last input frame flushes all output
// frames still due, with frames at or past it taking the final mono value;
// one input transaction gives at most 64 output transactions, and further
// inputs after the buffer only drain what remains. Sequence: a sample that
// does not complete a frame is only accumulated. A completing sample loads
// and starts the bit-serial divider that forms the average and waits for it,
// then passes a check state, then for each output frame a multiply, a round
// and a look-ahead state and one emit per output channel, held while the
// output side stalls, and finally a closing state that ends the step. A
// sample that arrives after the buffer skips the average and goes from its
// accept cycle straight to the check state. Input is taken only between
// steps.
// ----------------------------------------------------------------------------
module linear_interp_resampler_mixdown #(
  parameter int MAX_CHANNELS = lirm_pkg::MAX_CHANNELS_DEF,
  parameter int FRAME_BITS   = lirm_pkg::FRAME_BITS_DEF,
  parameter int SAMPLE_BITS  = lirm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [lirm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lirm_pkg::CFG_W-1:0]     cfg_data_i,
  // input samples
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  // output samples
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]  out_sample_o,
  output logic [lirm_pkg::CH_IDX_W-1:0]  channel_index_o,
  output logic [FRAME_BITS-1:0]          frame_index_o,
  output logic                           last_of_run_o,
  output logic                           end_of_buffer_o
);

  import lirm_pkg::*;

  // command and status between the sequencer and the datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: owns both handshakes and the end-of-run look-ahead
  lirm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .last_of_run_o (last_of_run_o),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  // datapath: registers, accumulation, divider, position and interpolation
  lirm_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAME_BITS   (FRAME_BITS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_sample_o    (out_sample_o),
    .channel_index_o (channel_index_o),
    .frame_index_o   (frame_index_o),
    .end_of_buffer_o (end_of_buffer_o)
  );

endmodule

// ===== dv/tb_linear_interp_resampler_mixdown.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler_mixdown
// self-checking testbench for the mono mix-down linear interpolation resampler
// ----------------------------------------------------------------------------
// One buffer is streamed through the block in phases. Each phase reprograms
// the registers while the block is idle and then sends whole input frames.
// A predictor in the testbench mirrors the block's state and queues the
// output transactions that each sample should cause. The monitor compares
// every output transaction field by field against the oldest entry in that
// queue. The last phases close the buffer, flush it past the result limit
// and drain further frames after the buffer, up to position saturation.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler_mixdown;
  import lirm_pkg::*;

  localparam int          SETTLE_CYCLES  = 300;   // longest step plus margin
  localparam int          WATCHDOG_LIMIT = 4000;  // cycles with no transaction
  localparam int          REPORT_CAP     = 100;
  localparam int unsigned FRAME_MASK     = 32'h000F_FFFF;
  localparam longint unsigned POS_MAX    = 64'h0000_000F_FFFF_FFFF;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // one output transaction as the block should present it
  typedef struct packed {
    logic signed [15:0] smp;
    logic [2:0]         chan;
    logic [19:0]        frame;
    logic               last_of_run;
    logic               end_of_buffer;
  } out_word_t;

  // dut ports
  logic               clk_i;
  logic               rst_ni    = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic [2:0]         channel_index;
  logic [19:0]        frame_index;
  logic               last_of_run;
  logic               end_of_buffer;

  // stimulus and expectations
  logic signed [15:0] sample_backlog[$];
  out_word_t          due_outputs[$];
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  int                 fail_count     = 0;
  int                 quiet_cycles   = 0;

  // shadow registers
  logic [3:0]  reg_in_ch     = 4'd1;
  logic [3:0]  reg_out_ch    = 4'd2;
  logic [19:0] reg_in_frames = 20'd2;
  logic [19:0] reg_out_frames = 20'd1;
  logic [23:0] reg_step      = 24'd65536;

  // shadow state of the resampler
  int              mix_sum       = 0;
  int unsigned     mix_count     = 0;
  longint          prev_mono     = 0;
  int unsigned     in_frame_cnt  = 0;
  longint unsigned src_pos       = 0;
  int unsigned     out_frame_cnt = 0;
  bit              buffer_done   = 1'b0;

  linear_interp_resampler_mixdown i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_sample_o   (out_sample),
    .channel_index_o(channel_index),
    .frame_index_o  (frame_index),
    .last_of_run_o  (last_of_run),
    .end_of_buffer_o(end_of_buffer)
  );

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // zero counts as one channel, anything past eight as eight
  function automatic int unsigned clamp_chan(logic [3:0] c);
    if (c == 4'd0) return 1;
    if (c > 4'd8) return 8;
    return c;
  endfunction

  // divide rounding to nearest, ties away from zero
  function automatic longint round_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  // prev + (cur - prev) * alpha, rounded and saturated to q1.15
  function automatic longint blend(longint a, longint b, logic [15:0] alpha);
    longint al;
    longint v;
    al = alpha;
    v = a + round_half_away((b - a) * al, 65536);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // queue one output frame on every output channel, then advance position
  function automatic int unsigned emit_frame(longint v, int unsigned och, int unsigned n);
    out_word_t w;
    bit        last_frame;
    last_frame = (out_frame_cnt + 1 == reg_out_frames);
    for (int unsigned c = 0; c < och; c++) begin
      w.smp           = v[15:0];
      w.chan          = c[2:0];
      w.frame         = out_frame_cnt[19:0];
      w.last_of_run   = 1'b0;
      w.end_of_buffer = last_frame && (c + 1 == och);
      due_outputs.push_back(w);
    end
    out_frame_cnt = (out_frame_cnt + 1) & FRAME_MASK;
    // position saturates at the top of its 36 bits
    src_pos = src_pos + reg_step;
    if (src_pos > POS_MAX) src_pos = POS_MAX;
    return n + och;
  endfunction

  function automatic void mixdown_and_resample(logic signed [15:0] smp);
    int unsigned och;
    int unsigned nin;
    int unsigned f;
    int unsigned n;
    longint      cur;
    longint      v;
    bit          closing;
    out_word_t   tail;
    och = clamp_chan(reg_out_ch);
    n = 0;
    if (!buffer_done) begin
      nin = clamp_chan(reg_in_ch);
      mix_sum += smp;
      mix_count++;
      if (mix_count < nin) return;
      cur = round_half_away(mix_sum, nin);
      f = in_frame_cnt;
      closing = (f + 1 >= reg_in_frames);
      // frames inside the window interpolate, on the closing frame the ones
      // at or past it take the final mono value
      while (out_frame_cnt < reg_out_frames && n + och <= MAX_RESULTS) begin
        if ((src_pos >> 16) >= f) begin
          if (!closing) break;
          v = cur;
        end else begin
          v = blend(prev_mono, cur, src_pos[15:0]);
        end
        n = emit_frame(v, och, n);
      end
      prev_mono = cur;
      mix_sum = 0;
      mix_count = 0;
      if (closing) buffer_done = 1'b1;
      else in_frame_cnt = (f + 1) & FRAME_MASK;
    end else begin
      // after the buffer each sample only drains frames still due
      while (out_frame_cnt < reg_out_frames && n + och <= MAX_RESULTS)
        n = emit_frame(prev_mono, och, n);
    end
    if (n > 0) begin
      tail = due_outputs.pop_back();
      tail.last_of_run = 1'b1;
      due_outputs.push_back(tail);
    end
  endfunction

  // ------------------------------------------------------------------------
  // clock, driver, monitor, watchdog
  // ------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: a stalled transaction holds, a free slot takes the next sample
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sample   <= '0;
    end else begin
      if (in_valid && !in_stall) mixdown_and_resample(sample);
      if (!in_valid || !in_stall) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          sample   <= sample_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  // monitor: random stall, compare each output transaction with the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t w;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $error("unexpected output: out_sample %0d frame_index %0d channel_index %0d",
                   out_sample, frame_index, channel_index);
        end else begin
          w = due_outputs.pop_front();
          check_field("out_sample", w.smp, out_sample);
          check_field("channel_index", w.chan, channel_index);
          check_field("frame_index", w.frame, frame_index);
          check_field("last_of_run", w.last_of_run, last_of_run);
          check_field("end_of_buffer", w.end_of_buffer, end_of_buffer);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // count cycles in which neither channel moves a transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_linear_interp_resampler_mixdown: FAIL");
    $finish;
  end

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------

  function automatic logic signed [15:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return 16'sh7FFF;
    if (pick == 1) return 16'sh8000;
    if (pick == 2) return 16'sh0000;
    if (pick == 3) return 16'shFFFF;
    return 16'($urandom);
  endfunction

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 64;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 64;
      end
      default: begin
        send_idle_pct = 11;
        recv_stall_pct = 11;
      end
    endcase
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [23:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_IN_CHANNELS:  reg_in_ch      = value[3:0];
      REG_OUT_CHANNELS: reg_out_ch     = value[3:0];
      REG_IN_FRAMES:    reg_in_frames  = value[19:0];
      REG_OUT_FRAMES:   reg_out_frames = value[19:0];
      default:          reg_step       = value;
    endcase
  endtask

  // only called while the block is idle
  task automatic configure(logic [3:0] ich, logic [3:0] och, logic [19:0] inf,
                           logic [19:0] outf, logic [23:0] step);
    write_reg(REG_IN_CHANNELS, {20'd0, ich});
    write_reg(REG_OUT_CHANNELS, {20'd0, och});
    write_reg(REG_IN_FRAMES, {4'd0, inf});
    write_reg(REG_OUT_FRAMES, {4'd0, outf});
    write_reg(REG_STEP_Q16, step);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // the sender holds off until every due output has come, then the block
  // gets time to finish a step that causes no output
  task automatic settle();
    while (sample_backlog.size() != 0 || in_valid || due_outputs.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(idle_mode_e mode, int unsigned n_items);
    set_idle(mode);
    repeat (n_items) sample_backlog.push_back(random_sample());
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset values would close the buffer on the second frame, so open it wide
    configure(4'd2, 4'd3, 20'hFFFFF, 20'hFFFFF, 24'd32768);

    // directed: full scale frames, rounding ties in both directions,
    // interpolation across the whole range
    set_idle(IDLE_NONE);
    sample_backlog = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                       16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8001,
                       16'sh0001, 16'sh0000, 16'shFFFF, 16'sh0000,
                       16'sh0000, 16'sh0000, 16'sh5555, 16'shAAAA,
                       16'sh7FFF, 16'sh7FFE, 16'shFFFE, 16'sh0001};
    settle();

    // step of one eighth: eight frames on eight channels, exactly the result limit
    configure(4'd1, 4'd8, 20'hFFFFF, 20'hFFFFF, 24'd8192);
    run_phase(IDLE_NONE, 8);

    // zero channel counts act as one
    configure(4'd0, 4'd0, 20'hFFFFF, 20'hFFFFF, 24'd65536);
    run_phase(IDLE_SENDER, 8);

    configure(4'd8, 4'd5, 20'hFFFFF, 20'hFFFFF, 24'd40000);
    run_phase(IDLE_RECEIVER, 8);

    // counts past eight clamp; a tiny step leaves frames behind their window
    configure(4'd15, 4'd15, 20'hFFFFF, 20'hFFFFF, 24'd1000);
    run_phase(IDLE_BOTH, 16);

    // output count already reached: input goes on with no output
    configure(4'd3, 4'd2, 20'hFFFFF, out_frame_cnt[19:0], 24'd98304);
    run_phase(IDLE_SENDER, 6);

    configure(4'd3, 4'd2, 20'hFFFFF, 20'hFFFFF, 24'd98304);
    run_phase(IDLE_RECEIVER, 12);

    // maximum step throws the position far past the input
    configure(4'd4, 4'd7, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
    run_phase(IDLE_BOTH, 8);

    // next frame is final: clamped flush of 320 outputs over several
    // transactions, later samples only drain and then are ignored
    configure(4'd2, 4'd8, 20'd1, out_frame_cnt[19:0] + 20'd40, 24'd8192);
    run_phase(IDLE_NONE, 10);

    // after the buffer: long drain on one channel, position hits saturation
    configure(4'd1, 4'd1, 20'hFFFFF, out_frame_cnt[19:0] + 20'd4200, 24'hFFFFFF);
    run_phase(IDLE_RECEIVER, 66);

    if (due_outputs.size() != 0) begin
      fail_count++;
      $error("%0d expected outputs never arrived", due_outputs.size());
    end
    if (fail_count == 0) begin
      $display("tb_linear_interp_resampler_mixdown: PASS");
    end else begin
      $display("tb_linear_interp_resampler_mixdown: FAIL");
    end
    $finish;
  end

endmodule
